// ===== rtl/core/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// String-to-integer parser package
// Shared types, character codes and digit decoding for the parser.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Parser phase within one string.
  typedef enum logic [2:0] {
    PhDone,
    PhWs,
    PhSigned,
    PhZero,
    PhHexPfx,
    PhDigits
  } stp_phase_e;

  // One input character with its control fields.
  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
    logic [5:0] radix;
  } stp_item_t;

  // Character codes.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowZ  = 8'h7A;

  // Digit values and bases. DigitNone is never below any 6-bit base.
  localparam logic [5:0] DigitNone    = 6'd63;
  localparam logic [5:0] LetterOffset = 6'd10;
  localparam logic [5:0] BaseAuto     = 6'd0;
  localparam logic [5:0] BaseOct      = 6'd8;
  localparam logic [5:0] BaseDec      = 6'd10;
  localparam logic [5:0] BaseHex      = 6'd16;

  // Value of a digit or letter, DigitNone for any other character.
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [5:0] d;
    if (c >= ChZero && c <= ChNine) begin
      d = 6'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      d = 6'(c - ChLowA) + LetterOffset;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = 6'(c - ChUpA) + LetterOffset;
    end else begin
      d = DigitNone;
    end
    return d;
  endfunction

  // Space, tab, line feed, vertical tab, form feed and carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

// ===== rtl/core/stp_in_if.sv =====
// ----------------------------------------------------------------------------
// Parser input channel
// Valid/ready channel that carries one character per transaction.
// ----------------------------------------------------------------------------
interface stp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;
  logic [5:0] radix;

  modport source (output valid, ch, start_req, radix, input ready);
  modport sink   (input valid, ch, start_req, radix, output ready);
endinterface

// ===== rtl/core/stp_out_if.sv =====
// ----------------------------------------------------------------------------
// Parser output channel
// Valid/ready channel that carries one parse result per transaction.
// ----------------------------------------------------------------------------
interface stp_out_if #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned POS_WIDTH   = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [POS_WIDTH-1:0]   end_pos;
  logic                   digits_found;

  modport source (output valid, value, end_pos, digits_found, input ready);
  modport sink   (input valid, value, end_pos, digits_found, output ready);
endinterface

// ===== rtl/core/stp_in_stage.sv =====
// ----------------------------------------------------------------------------
// Parser input register
// Captures one character transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module stp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  stp_in_if.sink            in_i,
  input  logic              take_i,
  output logic              valid_o,
  output stp_pkg::stp_item_t item_o
);
  import stp_pkg::*;

  logic      valid_q, valid_d;
  stp_item_t item_q;
  logic      load;

  // The register is free when empty or when its content leaves this cycle.
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.ch        <= in_i.ch;
      item_q.start_req <= in_i.start_req;
      item_q.radix     <= in_i.radix;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/stp_parse.sv =====
// ----------------------------------------------------------------------------
// Parser state and step logic
// Holds the per-string state and applies one character per cycle while no
// result waits: prefix handling, digit decoding, accumulator multiply-add.
// ----------------------------------------------------------------------------
module stp_parse #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned POS_WIDTH   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  stp_pkg::stp_item_t     item_i,
  output logic                   take_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [POS_WIDTH-1:0]   end_pos_o,
  output logic                   found_o
);
  import stp_pkg::*;

  localparam logic [POS_WIDTH-1:0] PosMax = {POS_WIDTH{1'b1}};

  stp_phase_e             phase_q, phase_d, cur_phase;
  logic                   neg_q, neg_d, cur_neg;
  logic [5:0]             base_q, base_d, cur_base;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d, cur_acc;
  logic                   any_q, any_d, cur_any;
  logic [POS_WIDTH-1:0]   pos_q, pos_d, cur_pos;

  logic [5:0]             digit;
  logic [5:0]             base_eff;
  logic [VALUE_WIDTH-1:0] mac;
  logic [VALUE_WIDTH-1:0] neg_acc;
  logic                   res;

  // A start character discards any string in progress.
  always_comb begin
    cur_phase = phase_q;
    cur_neg   = neg_q;
    cur_base  = base_q;
    cur_acc   = acc_q;
    cur_any   = any_q;
    cur_pos   = pos_q;
    if (item_i.start_req) begin
      cur_phase = PhWs;
      cur_neg   = 1'b0;
      cur_base  = item_i.radix;
      cur_acc   = '0;
      cur_any   = 1'b0;
      cur_pos   = '0;
    end
  end

  // Digit decode, effective base and the accumulator multiply-add.
  assign digit    = digit_value(item_i.ch);
  assign base_eff = (cur_base != BaseAuto) ? cur_base :
                    (cur_phase == PhZero)  ? BaseOct  : BaseDec;
  assign mac      = cur_acc * VALUE_WIDTH'(base_eff) + VALUE_WIDTH'(digit);
  assign neg_acc  = '0 - cur_acc;

  // Next state and result for the current character.
  always_comb begin
    logic begin_num;
    logic digit_path;
    begin_num  = 1'b0;
    digit_path = 1'b0;
    phase_d    = cur_phase;
    neg_d      = cur_neg;
    base_d     = cur_base;
    acc_d      = cur_acc;
    any_d      = cur_any;
    pos_d      = cur_pos;
    res        = 1'b0;
    value_o    = '0;
    end_pos_o  = '0;
    found_o    = 1'b0;

    if (cur_phase != PhDone && cur_pos != PosMax) begin
      pos_d = cur_pos + POS_WIDTH'(1);
    end

    unique case (cur_phase)
      PhWs: begin
        if (is_space(item_i.ch)) begin
          phase_d = PhWs;
        end else if (item_i.ch == ChPlus) begin
          phase_d = PhSigned;
        end else if (item_i.ch == ChMinus) begin
          neg_d   = 1'b1;
          phase_d = PhSigned;
        end else begin
          begin_num = 1'b1;
        end
      end
      PhSigned: begin
        begin_num = 1'b1;
      end
      PhZero: begin
        if (item_i.ch == ChLowX || item_i.ch == ChUpX) begin
          base_d  = BaseHex;
          phase_d = PhHexPfx;
        end else begin
          base_d     = base_eff;
          digit_path = 1'b1;
        end
      end
      PhHexPfx: begin
        if (digit < BaseHex) begin
          acc_d   = VALUE_WIDTH'(digit);
          any_d   = 1'b1;
          phase_d = PhDigits;
        end else begin
          // Bare hex prefix: the zero alone is the number.
          acc_d     = '0;
          res       = 1'b1;
          end_pos_o = cur_pos - POS_WIDTH'(1);
          found_o   = 1'b1;
          phase_d   = PhDone;
        end
      end
      PhDigits: begin
        digit_path = 1'b1;
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase

    // First character of the number: a zero may open an octal or hex prefix.
    if (begin_num) begin
      if (item_i.ch == ChZero && (cur_base == BaseAuto || cur_base == BaseHex)) begin
        acc_d   = '0;
        any_d   = 1'b1;
        phase_d = PhZero;
      end else begin
        base_d     = base_eff;
        digit_path = 1'b1;
      end
    end

    // Accept a digit or close the string.
    if (digit_path) begin
      if (digit < base_eff) begin
        acc_d   = mac;
        any_d   = 1'b1;
        phase_d = PhDigits;
      end else begin
        res       = 1'b1;
        value_o   = !cur_any ? '0 : (cur_neg ? neg_acc : cur_acc);
        end_pos_o = cur_any ? cur_pos : '0;
        found_o   = cur_any;
        phase_d   = PhDone;
      end
    end
  end

  // A character without a result never waits for the output side.
  assign res_valid_o = valid_i && res;
  assign take_o      = valid_i && (!res || res_ready_i);

  // Per-string state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDone;
      neg_q   <= 1'b0;
      base_q  <= '0;
      acc_q   <= '0;
      any_q   <= 1'b0;
      pos_q   <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      any_q   <= any_d;
      pos_q   <= pos_d;
    end
  end

  // An idle parser only wakes up on a start character.
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (phase_q != PhDone || item_i.start_req))
    else $error("result produced while idle without a start character");

  // A string without digits reports zero value and zero offset.
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !found_o) |-> (value_o == '0 && end_pos_o == '0))
    else $error("empty parse reports a nonzero value or offset");

  // A delivered result closes the string.
  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && res_valid_o) |=> (phase_q == PhDone))
    else $error("parser did not return to idle after a result");

  // The digit phase is only entered after a digit.
  a_digits_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDigits) |-> any_q)
    else $error("digit phase without any digit recorded");

endmodule

// ===== rtl/core/stp_out_stage.sv =====
// ----------------------------------------------------------------------------
// Parser output register
// Holds one result until the output transaction completes.
// ----------------------------------------------------------------------------
module stp_out_stage #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned POS_WIDTH   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_valid_i,
  output logic                   load_ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [POS_WIDTH-1:0]   end_pos_i,
  input  logic                   found_i,
  stp_out_if.source              out_o
);

  logic                   valid_q, valid_d;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [POS_WIDTH-1:0]   end_pos_q;
  logic                   found_q;
  logic                   load;

  // Free when empty or when the held result is taken this cycle.
  assign load_ready_o = !valid_q || out_o.ready;
  assign load         = load_valid_i && load_ready_o;
  assign valid_d      = load || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q   <= value_i;
      end_pos_q <= end_pos_i;
      found_q   <= found_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.value        = value_q;
  assign out_o.end_pos      = end_pos_q;
  assign out_o.digits_found = found_q;

endmodule

// ===== rtl/core/string_to_integer_parser_top.sv =====
// ----------------------------------------------------------------------------
// String-to-integer parser, top level
// Takes one character per transaction and gives one result per string.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result register can accept;
//   the accumulator loop (a multiply by the 6-bit base plus the digit add)
//   is combinational.
// Results: the parser works from the input register, and the result register
//   loads a result as the parser takes its terminating character.
// Reset: asynchronous, active low; clears the valid flags of both channel
//   registers and idles the parser, which then waits for a start character.
module string_to_integer_parser_top #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned POS_WIDTH   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o
);
  import stp_pkg::*;

  logic                   item_valid;
  stp_item_t              item;
  logic                   take;
  logic                   res_valid;
  logic                   res_ready;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [POS_WIDTH-1:0]   res_end_pos;
  logic                   res_found;

  // Input register.
  stp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  // Parser state and step logic.
  stp_parse #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .POS_WIDTH   (POS_WIDTH)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .value_o     (res_value),
    .end_pos_o   (res_end_pos),
    .found_o     (res_found)
  );

  // Result register.
  stp_out_stage #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .POS_WIDTH   (POS_WIDTH)
  ) u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .load_ready_o (res_ready),
    .value_i      (res_value),
    .end_pos_i    (res_end_pos),
    .found_i      (res_found),
    .out_o        (out_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// String-to-integer parser testbench
// Streams characters through the parser and checks each parse result against
// a cycle-free model of the parse. A short table of strings comes first and
// covers idle input, restart, the bare hex prefix, odd radixes and the field
// extremes. One string with a long run of leading blanks follows. Random
// strings follow, mostly well formed with random content, plus noise. The
// sender idles and the receiver stalls at several rates, and the receiver
// holds off once for a long stretch so that the parser fills up.
// ----------------------------------------------------------------------------
module tb;
  import stp_pkg::*;

  localparam int unsigned ValueWidth    = 64;
  localparam int unsigned PosWidth      = 16;
  localparam int          WatchdogLimit = 4000;
  localparam int          HoldCycles    = 400;
  localparam int          PhaseItems    = 200;
  localparam int          DirRows       = 28;
  localparam int          DigitAbsent   = 99;
  localparam int          LongRun       = 40;

  // One parse result as the output channel carries it.
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [PosWidth-1:0]   end_pos;
    logic                  found;
  } parse_res_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic [5:0] radix;
    logic       typed;
    logic       has_res;
    parse_res_t want;
  } dir_row_t;

  localparam parse_res_t NoRes = '0;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  stp_in_if                                                  in_if ();
  stp_out_if #(.VALUE_WIDTH(ValueWidth), .POS_WIDTH(PosWidth)) out_if ();

  string_to_integer_parser_top #(
    .VALUE_WIDTH(ValueWidth),
    .POS_WIDTH  (PosWidth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Model state of the parse in progress.
  stp_phase_e            pr_phase;
  logic                  pr_negative;
  logic [5:0]            pr_base;
  logic [ValueWidth-1:0] pr_acc;
  logic                  pr_any;
  logic [PosWidth-1:0]   pr_pos;

  parse_res_t pending_results[$];
  int         err_count       = 0;
  int         results_checked = 0;
  int         chars_parsed    = 0;
  int         quiet_cycles    = 0;
  int         tx_gap_pct      = 0;
  int         rx_stall_pct    = 0;
  logic       hold_rx         = 1'b0;

  // Directed strings: idle input, signed auto-hex, bare hex prefix, restart,
  // sign without digits, radix one, radix above 36, octal and radix 36.
  dir_row_t dir_tab [DirRows] = '{
    '{"Z",   1'b0, 6'd0,  1'b1, 1'b0, NoRes},
    '{8'hFF, 1'b0, 6'd63, 1'b1, 1'b0, NoRes},
    '{" ",   1'b1, 6'd0,  1'b0, 1'b0, NoRes},
    '{"-",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"0",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"X",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"f",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"F",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 6'd63, 1'b0, 1'b0, NoRes},
    '{"0",   1'b1, 6'd16, 1'b0, 1'b0, NoRes},
    '{"x",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"g",   1'b0, 6'd0,  1'b1, 1'b1, '{64'd0, 16'd1, 1'b1}},
    '{"1",   1'b1, 6'd10, 1'b0, 1'b0, NoRes},
    '{"2",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"7",   1'b1, 6'd10, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 6'd0,  1'b1, 1'b1, '{64'd7, 16'd1, 1'b1}},
    '{"+",   1'b1, 6'd10, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 6'd0,  1'b1, 1'b1, '{64'd0, 16'd0, 1'b0}},
    '{"0",   1'b1, 6'd1,  1'b0, 1'b0, NoRes},
    '{"1",   1'b0, 6'd0,  1'b1, 1'b1, '{64'd0, 16'd1, 1'b1}},
    '{"z",   1'b1, 6'd63, 1'b0, 1'b0, NoRes},
    '{"Z",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"0",   1'b1, 6'd0,  1'b0, 1'b0, NoRes},
    '{"7",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"8",   1'b0, 6'd0,  1'b0, 1'b0, NoRes},
    '{"z",   1'b1, 6'd36, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 6'd0,  1'b1, 1'b1, '{64'd35, 16'd1, 1'b1}}
  };

  // Value of a character as a digit, DigitAbsent when it is neither a
  // decimal digit nor a letter.
  function automatic int char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c) - int'("0");
    end
    if (c >= "a" && c <= "z") begin
      return int'(c) - int'("a") + 10;
    end
    if (c >= "A" && c <= "Z") begin
      return int'(c) - int'("A") + 10;
    end
    return DigitAbsent;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [7:0] digit_char(input int dv, input bit upper);
    if (dv < 10) begin
      return ChZero + 8'(dv);
    end
    return (upper ? ChUpA : ChLowA) + 8'(dv - 10);
  endfunction

  function automatic void clear_parse();
    pr_phase    = PhDone;
    pr_negative = 1'b0;
    pr_base     = BaseAuto;
    pr_acc      = '0;
    pr_any      = 1'b0;
    pr_pos      = '0;
  endfunction

  // Close the string: signed, wrapped value and end offset.
  function automatic parse_res_t close_string(input logic [PosWidth-1:0] end_at,
                                              input logic found);
    parse_res_t res;
    res.value   = pr_negative ? -pr_acc : pr_acc;
    res.end_pos = end_at;
    res.found   = found;
    if (!found) begin
      res.value   = '0;
      res.end_pos = '0;
    end
    pr_phase = PhDone;
    return res;
  endfunction

  // Advance the parse by one accepted character. Returns 1 when the
  // character ends a string; counted tells whether it was parsed at all.
  function automatic bit parse_char(input logic [7:0] c, input logic st,
                                    input logic [5:0] r, output parse_res_t res,
                                    output bit counted);
    logic [PosWidth-1:0] here;
    bit                  as_digit;
    int                  d;
    res      = '0;
    counted  = 1'b0;
    as_digit = 1'b0;
    if (st) begin
      clear_parse();
      pr_phase = PhWs;
      pr_base  = r;
    end
    if (pr_phase == PhDone) begin
      return 1'b0;
    end
    counted = 1'b1;
    here    = pr_pos;
    if (pr_pos != {PosWidth{1'b1}}) begin
      pr_pos = pr_pos + 1'b1;
    end
    case (pr_phase)
      PhWs, PhSigned: begin
        if (pr_phase == PhWs && is_blank(c)) begin
          return 1'b0;
        end else if (pr_phase == PhWs && c == ChPlus) begin
          pr_phase = PhSigned;
        end else if (pr_phase == PhWs && c == ChMinus) begin
          pr_negative = 1'b1;
          pr_phase    = PhSigned;
        end else if (c == ChZero && (pr_base == BaseAuto || pr_base == BaseHex)) begin
          pr_acc   = '0;
          pr_any   = 1'b1;
          pr_phase = PhZero;
        end else begin
          if (pr_base == BaseAuto) pr_base = BaseDec;
          as_digit = 1'b1;
        end
      end
      PhZero: begin
        if (c == ChLowX || c == ChUpX) begin
          pr_base  = BaseHex;
          pr_phase = PhHexPfx;
        end else begin
          if (pr_base == BaseAuto) pr_base = BaseOct;
          as_digit = 1'b1;
        end
      end
      PhHexPfx: begin
        d = char_digit(c);
        if (d < 16) begin
          pr_acc   = ValueWidth'(d);
          pr_any   = 1'b1;
          pr_phase = PhDigits;
        end else begin
          // Only the zero of the prefix counts as a digit.
          pr_acc = '0;
          res    = close_string(here - 1'b1, 1'b1);
          return 1'b1;
        end
      end
      default: begin
        as_digit = 1'b1;
      end
    endcase
    if (as_digit) begin
      d = char_digit(c);
      if (d < int'(pr_base)) begin
        pr_acc   = pr_acc * ValueWidth'(pr_base) + ValueWidth'(d);
        pr_any   = 1'b1;
        pr_phase = PhDigits;
      end else begin
        res = close_string(here, pr_any);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [ValueWidth-1:0] got,
                                 input logic [ValueWidth-1:0] want);
    $display("tb: mismatch in %s at %0t: got %h, expected %h", what, $realtime, got,
             want);
    err_count++;
  endtask

  // Offer one character, wait for its transaction and record what it causes.
  task automatic send_char(input logic [7:0] c, input logic st, input logic [5:0] r,
                           input bit typed, input bit has_res, input parse_res_t want);
    parse_res_t res;
    bit         ends;
    bit         counted;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.ch        <= c;
    in_if.start_req <= st;
    in_if.radix     <= r;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    ends = parse_char(c, st, r, res, counted);
    if (typed) begin
      if (has_res) pending_results.push_back(want);
    end else if (ends) begin
      pending_results.push_back(res);
    end
    if (counted) chars_parsed++;
  endtask

  function automatic logic [5:0] pick_radix();
    case ($urandom_range(9))
      0, 1, 2: return BaseAuto;
      3:       return BaseHex;
      4:       return BaseDec;
      5:       return BaseOct;
      6:       return 6'd2;
      7:       return 6'd36;
      8:       return 6'd1;
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  // One random string: mostly well formed, some with no digits, some noise.
  task automatic send_random_string();
    logic [7:0] txt[$];
    logic [7:0] c;
    logic [5:0] r;
    int         sel;
    int         ws_sel;
    int         n_dig;
    int         lim;
    bit         hex_pfx;
    sel = $urandom_range(99);
    if (sel < 12) begin
      repeat ($urandom_range(8, 1)) begin
        send_char(8'($urandom_range(255)), $urandom_range(3) == 0,
                  6'($urandom_range(63)), 1'b0, 1'b0, NoRes);
      end
      return;
    end
    r = pick_radix();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        ws_sel = $urandom_range(5);
        txt.push_back(ws_sel == 5 ? ChSpace : ChTab + 8'(ws_sel));
      end
    end
    case ($urandom_range(3))
      0: txt.push_back(ChPlus);
      1: txt.push_back(ChMinus);
      default: ;
    endcase
    hex_pfx = 1'b0;
    if ((r == BaseAuto || r == BaseHex) && $urandom_range(2) == 0) begin
      txt.push_back(ChZero);
      txt.push_back($urandom_range(1) ? ChLowX : ChUpX);
      hex_pfx = 1'b1;
    end
    if (hex_pfx) lim = 16;
    else if (r == BaseAuto) lim = 10;
    else if (r > 6'd36) lim = 36;
    else lim = int'(r);
    if (sel < 20) n_dig = 0;
    else if ($urandom_range(9) == 0) n_dig = $urandom_range(24, 10);
    else n_dig = $urandom_range(6, 1);
    repeat (n_dig) txt.push_back(digit_char($urandom_range(lim - 1), $urandom_range(1)));
    // Terminator: mostly NUL, else some other byte.
    case ($urandom_range(3))
      0, 1: c = 8'h00;
      2: begin
        c = 8'($urandom_range(255));
        while (char_digit(c) != DigitAbsent) c = 8'($urandom_range(255));
      end
      default: c = 8'($urandom_range(255));
    endcase
    txt.push_back(c);
    foreach (txt[i]) begin
      send_char(txt[i], i == 0, (i == 0) ? r : 6'($urandom_range(63)), 1'b0, 1'b0, NoRes);
    end
    // Now and then a character that the idle parser should drop.
    if ($urandom_range(7) == 0) begin
      send_char(8'($urandom_range(255)), 1'b0, 6'($urandom_range(63)), 1'b0, 1'b0, NoRes);
    end
  endtask

  task automatic random_phase(input int gap_pct, input int stall_pct);
    int first;
    tx_gap_pct   = gap_pct;
    rx_stall_pct <= stall_pct;
    first        = chars_parsed;
    while (chars_parsed - first < PhaseItems) send_random_string();
  endtask

  always #10 clk = ~clk;

  // Receiver: random ready, and the check of each result transaction.
  always @(posedge clk or negedge rst_n) begin
    parse_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_if.value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.value !== want.value) begin
            report_mismatch("value", out_if.value, want.value);
          end
          if (out_if.end_pos !== want.end_pos) begin
            report_mismatch("end_pos", ValueWidth'(out_if.end_pos),
                            ValueWidth'(want.end_pos));
          end
          if (out_if.digits_found !== want.found) begin
            report_mismatch("digits_found", ValueWidth'(out_if.digits_found),
                            ValueWidth'(want.found));
          end
        end
        results_checked++;
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Main sequence.
  initial begin
    int first;
    in_if.valid     = 1'b0;
    in_if.ch        = '0;
    in_if.start_req = 1'b0;
    in_if.radix     = '0;
    clear_parse();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling.
    foreach (dir_tab[i]) begin
      send_char(dir_tab[i].ch, dir_tab[i].start, dir_tab[i].radix, dir_tab[i].typed,
                dir_tab[i].has_res, dir_tab[i].want);
    end

    // A long run of leading blanks before a one-digit number.
    send_char(ChSpace, 1'b1, BaseDec, 1'b0, 1'b0, NoRes);
    repeat (LongRun) send_char(ChSpace, 1'b0, BaseAuto, 1'b0, 1'b0, NoRes);
    send_char("5", 1'b0, BaseAuto, 1'b0, 1'b0, NoRes);
    send_char(8'h00, 1'b0, BaseAuto, 1'b0, 1'b0, NoRes);

    // The receiver holds off while the sender keeps offering characters.
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    first = chars_parsed;
    while (chars_parsed - first < 40) send_random_string();

    random_phase(0, 0);
    random_phase(77, 0);
    random_phase(0, 77);
    random_phase(6, 6);

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: parsed %0d characters and checked %0d results", chars_parsed,
             results_checked);
    $display("tb: %0d mismatches over directed, long-blank, held-off and random phases",
             err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
